// ===== rtl/core/plpl_pkg.sv =====
// Shared types and constants for the piecewise linear lookup core.
`default_nettype none
package plpl_pkg;

	localparam int DATA_W         = 32;
	localparam int FRAC_W         = 16;
	localparam int CFG_W          = 7;
	localparam int INDEX_W        = 6;
	localparam int DEF_MAX_POINTS = 64;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_DONE
	} plpl_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/plpl_store.sv =====
// Breakpoint key and value memories with one write port and one registered read port.
`default_nettype none
module plpl_store #(
	parameter int MAX_POINTS = plpl_pkg::DEF_MAX_POINTS
) (
	input  wire logic                                clk,
	input  wire logic                                wr_en,
	input  wire logic [$clog2(MAX_POINTS)-1:0]       wr_addr,
	input  wire logic [plpl_pkg::DATA_W-1:0]         wr_key,
	input  wire logic [plpl_pkg::DATA_W-1:0]         wr_value,
	input  wire logic                                rd_en,
	input  wire logic [$clog2(MAX_POINTS)-1:0]       rd_addr,
	output logic      [plpl_pkg::DATA_W-1:0]         rd_key,
	output logic      [plpl_pkg::DATA_W-1:0]         rd_value
);
	import plpl_pkg::*;

	logic [DATA_W-1:0] key_mem   [MAX_POINTS];
	logic [DATA_W-1:0] value_mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]   <= wr_key;
			value_mem[wr_addr] <= wr_value;
		end
		if (rd_en) begin
			rd_key   <= key_mem[rd_addr];
			rd_value <= value_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/plpl_div.sv =====
// Restoring divider that produces the 16-bit interpolation fraction, one bit per cycle.
`default_nettype none
module plpl_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [plpl_pkg::DATA_W-1:0]   dividend,
	input  wire logic [plpl_pkg::DATA_W-1:0]   divisor,
	output logic                               done,
	output logic      [plpl_pkg::FRAC_W-1:0]   quotient
);
	import plpl_pkg::*;

	localparam int CNT_W = $clog2(FRAC_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic [FRAC_W-1:0] quot_q;
	logic              done_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              fits;

	// The dividend is always below the divisor, so the remainder fits in DATA_W bits.
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			den_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			quot_q <= {quot_q[FRAC_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule
`default_nettype wire

// ===== rtl/core/piecewise_linear_lookup_core.sv =====
// Piecewise linear lookup: breakpoint table, ordered scan, fraction divide and interpolation.
//
// Input words carry either a breakpoint write (req_type 0) or a query (req_type 1).
// A word is taken when in_valid is high and in_stall is low. A write stores the
// key and value at point_index and gives no result; writes to an index at or
// above MAX_POINTS are dropped. A query scans entries 0 upward, one memory read
// per cycle, for the first key greater than query_x, then divides and multiplies to
// interpolate. The scan is paced by the single read port of the breakpoint memory
// and the divide by the one-bit-per-cycle divider. One query is in flight at a
// time. Results leave through an output register: out_valid holds with its word
// while out_stall is high, and a new word is taken while a finished result waits.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets point_count;
// cfg_ready is always high. Reset sets point_count to 1 and empties the output;
// the memories are not cleared and must be written before they are queried.
`default_nettype none
module piecewise_linear_lookup_core #(
	parameter int MAX_POINTS = plpl_pkg::DEF_MAX_POINTS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic        [plpl_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 req_type,
	input  wire logic        [plpl_pkg::INDEX_W-1:0]  point_index,
	input  wire logic signed [plpl_pkg::DATA_W-1:0]   point_key,
	input  wire logic signed [plpl_pkg::DATA_W-1:0]   point_value,
	input  wire logic signed [plpl_pkg::DATA_W-1:0]   query_x,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed      [plpl_pkg::DATA_W-1:0]   interp_value,
	output logic                                      below_first,
	output logic                                      at_or_above_last
);
	import plpl_pkg::*;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int PROD_W = FRAC_W + DATA_W + 2;

	plpl_state_t state_q, state_d;

	logic [CFG_W-1:0]          point_count_q;
	logic [CNT_W-1:0]          n_eff;
	logic [CNT_W-1:0]          last_idx;

	logic                      in_acc;
	logic                      wr_en;
	logic                      rd_en;
	logic [DATA_W-1:0]         rd_key;
	logic [DATA_W-1:0]         rd_value;

	logic [CNT_W-1:0]          issue_q;
	logic                      rvalid_s1;
	logic [CNT_W-1:0]          ridx_s1;

	logic signed [DATA_W-1:0]  x_q;
	logic [DATA_W-1:0]         prev_key_q;
	logic [DATA_W-1:0]         prev_value_q;
	logic                      key_hit;
	logic                      at_last;
	logic                      decide;
	logic                      div_start;
	logic                      div_done;
	logic [FRAC_W-1:0]         frac;
	logic [DATA_W:0]           dx_w;
	logic [DATA_W:0]           span_w;

	logic signed [DATA_W-1:0]  yl_q;
	logic signed [DATA_W:0]    dy_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  sum_w;

	logic [DATA_W-1:0]         res_q;
	logic                      below_q;
	logic                      above_q;

	logic                      out_valid_q;
	logic [DATA_W-1:0]         out_value_q;
	logic                      out_below_q;
	logic                      out_above_q;
	logic                      out_free;
	logic                      out_load;

	// A count of zero acts as one; counts beyond the table saturate.
	always_comb begin
		if (point_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (int'(point_count_q) > MAX_POINTS) begin
			n_eff = CNT_W'(MAX_POINTS);
		end else begin
			n_eff = CNT_W'(point_count_q);
		end
	end
	assign last_idx = n_eff - CNT_W'(1);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			point_count_q <= cfg_data;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign wr_en    = in_acc && (req_type == REQ_WRITE) && (int'(point_index) < MAX_POINTS);

	assign key_hit = rvalid_s1 && ($signed(rd_key) > x_q);
	assign at_last = rvalid_s1 && !key_hit && (ridx_s1 == last_idx);
	assign decide  = key_hit || at_last;

	assign rd_en     = (state_q == ST_SCAN) && (issue_q < n_eff) && !decide;
	assign div_start = (state_q == ST_SCAN) && key_hit && (ridx_s1 != '0);

	// Both differences are non-negative and below 2^32 once the scan has stopped on a hit.
	assign dx_w   = {x_q[DATA_W-1], x_q} - {prev_key_q[DATA_W-1], prev_key_q};
	assign span_w = {rd_key[DATA_W-1], rd_key} - {prev_key_q[DATA_W-1], prev_key_q};

	plpl_store #(
		.MAX_POINTS(MAX_POINTS)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (IDX_W'(point_index)),
		.wr_key   (point_key),
		.wr_value (point_value),
		.rd_en    (rd_en),
		.rd_addr  (issue_q[IDX_W-1:0]),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	plpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dx_w[DATA_W-1:0]),
		.divisor  (span_w[DATA_W-1:0]),
		.done     (div_done),
		.quotient (frac)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (req_type == REQ_QUERY)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (div_start) begin
					state_d = ST_DIV;
				end else if (decide) begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sum_w = (prod_q >>> FRAC_W) + $signed({{(PROD_W - DATA_W){yl_q[DATA_W-1]}}, yl_q});

	always_ff @(posedge clk) begin
		if (in_acc && (req_type == REQ_QUERY)) begin
			x_q     <= query_x;
			issue_q <= '0;
		end else if (rd_en) begin
			issue_q <= issue_q + CNT_W'(1);
		end
		ridx_s1 <= issue_q;

		if ((state_q == ST_SCAN) && rvalid_s1) begin
			if (!decide) begin
				prev_key_q   <= rd_key;
				prev_value_q <= rd_value;
			end else if (at_last) begin
				res_q   <= rd_value;
				below_q <= 1'b0;
				above_q <= 1'b1;
			end else if (ridx_s1 == '0) begin
				res_q   <= rd_value;
				below_q <= 1'b1;
				above_q <= 1'b0;
			end else begin
				yl_q    <= $signed(prev_value_q);
				dy_q    <= $signed({rd_value[DATA_W-1], rd_value})
					- $signed({prev_value_q[DATA_W-1], prev_value_q});
				below_q <= 1'b0;
				above_q <= 1'b0;
			end
		end

		if (state_q == ST_MUL) begin
			prod_q <= $signed({1'b0, frac}) * dy_q;
		end
		// Arithmetic shift floors the scaled product toward minus infinity.
		if (state_q == ST_SUM) begin
			res_q <= sum_w[DATA_W-1:0];
		end

		if (out_load) begin
			out_value_q <= res_q;
			out_below_q <= below_q;
			out_above_q <= above_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign interp_value     = $signed(out_value_q);
	assign below_first      = out_below_q;
	assign at_or_above_last = out_above_q;

endmodule
`default_nettype wire

// ===== tb/plpl_checker.sv =====
// Checker for the lookup core: watches the channels, predicts and compares results.
module plpl_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic        [plpl_pkg::CFG_W-1:0]    cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 req_type,
	input  logic        [plpl_pkg::INDEX_W-1:0]  point_index,
	input  logic signed [plpl_pkg::DATA_W-1:0]   point_key,
	input  logic signed [plpl_pkg::DATA_W-1:0]   point_value,
	input  logic signed [plpl_pkg::DATA_W-1:0]   query_x,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [plpl_pkg::DATA_W-1:0]   interp_value,
	input  logic                                 below_first,
	input  logic                                 at_or_above_last,
	output int                                   mismatches,
	output int                                   outstanding
);
	import plpl_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     below;
		logic                     above;
	} lookup_t;

	logic signed [DATA_W-1:0] key_mem   [DEF_MAX_POINTS];
	logic signed [DATA_W-1:0] value_mem [DEF_MAX_POINTS];
	logic        [CFG_W-1:0]  count_reg = CFG_W'(1);
	lookup_t                  lookups_due [$];
	lookup_t                  want;
	int                       err_total = 0;
	int                       pending_n = 0;

	assign mismatches  = err_total;
	assign outstanding = pending_n;

	function automatic lookup_t interpolate(input logic signed [DATA_W-1:0] x);
		int      n;
		int      i;
		longint  xl, xr, yl, yr, frac, prod;
		lookup_t r;
		n = int'(count_reg);
		if (n == 0) n = 1;
		if (n > DEF_MAX_POINTS) n = DEF_MAX_POINTS;
		i = 0;
		while (i < n && key_mem[i] <= x) i++;
		r = '0;
		if (i == n) begin
			r.value = value_mem[n-1];
			r.above = 1'b1;
		end else if (i == 0) begin
			r.value = value_mem[0];
			r.below = 1'b1;
		end else begin
			xl = key_mem[i-1];
			xr = key_mem[i];
			yl = value_mem[i-1];
			yr = value_mem[i];
			// The left key never exceeds x, so the divisor is positive.
			frac = ((longint'(x) - xl) <<< FRAC_W) / (xr - xl);
			prod = frac * (yr - yl);
			r.value = DATA_W'(yl + (prod >>> FRAC_W));
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_reg = CFG_W'(1);
			lookups_due.delete();
			pending_n <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lookups_due.size() == 0) begin
					err_total++;
					if (err_total <= 10)
						$display("result word with nothing due: value %h below %b above %b",
							interp_value, below_first, at_or_above_last);
				end else begin
					want = lookups_due.pop_front();
					if (want.value !== interp_value || want.below !== below_first ||
							want.above !== at_or_above_last) begin
						err_total++;
						if (err_total <= 10)
							$display({"mismatch: value exp %h got %h, ",
								"below exp %b got %b, above exp %b got %b"},
								want.value, interp_value, want.below, below_first,
								want.above, at_or_above_last);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (req_type == REQ_QUERY) begin
					lookups_due.insert(lookups_due.size(), interpolate(query_x));
				end else if (int'(point_index) < DEF_MAX_POINTS) begin
					key_mem[point_index]   = point_key;
					value_mem[point_index] = point_value;
				end
			end
			if (cfg_valid && cfg_ready) count_reg = cfg_data;
			pending_n <= lookups_due.size();
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// Top of the lookup core testbench: clock, reset, stimulus and the final verdict.
module tb_top;
	import plpl_pkg::*;

	localparam int     CYCLE_LIMIT = 2000000;
	localparam int     SETTLE      = 120;
	localparam longint KEY_MIN     = -64'sd2147483648;
	localparam longint KEY_MAX     = 64'sd2147483647;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       cfg_valid   = 1'b0;
	logic                       cfg_ready;
	logic        [CFG_W-1:0]    cfg_data    = '0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic                       req_type    = REQ_WRITE;
	logic        [INDEX_W-1:0]  point_index = '0;
	logic signed [DATA_W-1:0]   point_key   = '0;
	logic signed [DATA_W-1:0]   point_value = '0;
	logic signed [DATA_W-1:0]   query_x     = '0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic signed [DATA_W-1:0]   interp_value;
	logic                       below_first;
	logic                       at_or_above_last;
	int                         mismatches;
	int                         outstanding;

	logic   calm        = 1'b0;
	int     stall_run   = 0;
	int     cycle_count = 0;
	longint tbl_key [DEF_MAX_POINTS];

	piecewise_linear_lookup_core dut (.*);
	plpl_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure: mostly short random stalls, now and then a long run.
	always @(posedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
			stall_run <= 0;
		end else if (stall_run != 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else if ($urandom_range(0, 199) == 0) begin
			out_stall <= 1'b1;
			stall_run <= $urandom_range(10, 80);
		end else begin
			out_stall <= ($urandom_range(0, 99) < 24);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic longint rnd_span(input longint span);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return longint'(r % 64'(span));
	endfunction

	function automatic logic signed [DATA_W-1:0] fit32(input longint v);
		if (v > KEY_MAX) v = KEY_MAX;
		if (v < KEY_MIN) v = KEY_MIN;
		return v[DATA_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_val();
		if ($urandom_range(0, 1)) return $urandom;
		return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
	endfunction

	function automatic int eff_points(input int c);
		if (c == 0) return 1;
		if (c > DEF_MAX_POINTS) return DEF_MAX_POINTS;
		return c;
	endfunction

	// Query abscissas cluster on keys, their neighbors and the spans between them.
	function automatic logic signed [DATA_W-1:0] pick_x(input int n);
		longint x;
		int     i;
		int     r;
		i = $urandom_range(0, n - 1);
		r = $urandom_range(0, 99);
		if (r < 30)
			x = tbl_key[i];
		else if (r < 45)
			x = tbl_key[i] + ($urandom_range(0, 1) ? 1 : -1);
		else if (r < 75 && i + 1 < n && tbl_key[i+1] > tbl_key[i])
			x = tbl_key[i] + rnd_span(tbl_key[i+1] - tbl_key[i]);
		else if (r >= 75 && r < 88)
			x = $urandom_range(0, 1) ? tbl_key[0] - 1 - rnd_span(64'sd1 << 20)
				: tbl_key[n-1] + rnd_span(64'sd1 << 20);
		else if (r >= 88 && r < 94)
			x = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
		else
			x = longint'($signed($urandom));
		return fit32(x);
	endfunction

	task automatic send_word(input logic kind, input logic [INDEX_W-1:0] idx,
			input logic signed [DATA_W-1:0] k, input logic signed [DATA_W-1:0] v,
			input logic signed [DATA_W-1:0] x);
		int gap;
		req_type    <= kind;
		point_index <= idx;
		point_key   <= k;
		point_value <= v;
		query_x     <= x;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!calm && $urandom_range(0, 99) < 24) begin
			gap = 1;
			while ($urandom_range(0, 99) < 40) gap++;
			if ($urandom_range(0, 49) == 0) gap += $urandom_range(20, 100);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_point(input int idx, input logic signed [DATA_W-1:0] k,
			input logic signed [DATA_W-1:0] v);
		tbl_key[idx] = k;
		send_word(REQ_WRITE, INDEX_W'(idx), k, v, $urandom);
	endtask

	task automatic query(input logic signed [DATA_W-1:0] x);
		send_word(REQ_QUERY, INDEX_W'($urandom), $urandom, $urandom, x);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// The count register changes only once the core is idle and a write word has settled.
	task automatic set_count(input int c);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(c);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Strictly ascending keys over a tight, a medium or the full span; noisy tables
	// also get repeated and scattered keys.
	task automatic load_table(input int n, input bit noisy);
		longint span;
		longint base;
		longint step;
		longint k;
		int     i;
		case ($urandom_range(0, 2))
			0:       span = longint'(n) * longint'($urandom_range(1, 8));
			1:       span = longint'(n) * longint'($urandom_range(1, 1 << 18));
			default: span = 64'sd4294967295;
		endcase
		base = KEY_MIN + rnd_span(64'sd4294967296 - span);
		step = span / n;
		for (i = 0; i < n; i++) begin
			k = base + i * step + rnd_span(step);
			if (noisy && $urandom_range(0, 7) == 0)
				k = (i > 0 && $urandom_range(0, 1)) ? tbl_key[i-1] : longint'($signed($urandom));
			write_point(i, fit32(k), rand_val());
		end
	endtask

	initial begin : stimulus
		int     ph;
		int     q;
		int     c;
		int     n;
		int     idx;
		bit     noisy;
		longint k;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single point at the reset count: below, on and beyond the only key.
		write_point(0, 0, 32'sh7FFFFFFF);
		query(-1);
		query(0);
		query(32'sh7FFFFFFF);
		query(32'sh80000000);
		// A count of zero behaves as one point.
		set_count(0);
		query(-5);
		query(100);
		// Two points at the extremes of the key range, rising then falling values.
		write_point(0, 32'sh80000000, 32'sh80000000);
		write_point(1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		set_count(2);
		query(32'sh80000000);
		query(0);
		query(32'sh7FFFFFFE);
		query(32'sh7FFFFFFF);
		write_point(0, 32'sh80000000, 32'sh7FFFFFFF);
		write_point(1, 32'sh7FFFFFFF, 32'sh80000000);
		query(0);
		query(32'sh7FFFFFFE);
		// Keys one apart.
		write_point(0, 100, 5);
		write_point(1, 101, -7);
		query(99);
		query(100);
		query(101);

		for (ph = 0; ph < 10; ph++) begin
			case (ph)
				0:       c = 64;
				1:       c = 127;
				2:       c = 1;
				3:       c = 2;
				4:       c = 0;
				5:       c = 65;
				7:       c = $urandom_range(66, 126);
				9:       c = 64;
				default: c = $urandom_range(3, 63);
			endcase
			calm <= (ph == 6);
			set_count(c);
			n = eff_points(c);
			noisy = (ph % 3 == 2);
			load_table(n, noisy);
			for (q = 0; q < 90; q++) begin
				if (q == 45) wait_drained();
				if ($urandom_range(0, 9) == 0) begin
					idx = $urandom_range(0, DEF_MAX_POINTS - 1);
					if (idx < n && !(noisy && $urandom_range(0, 1)))
						k = tbl_key[idx];
					else
						k = longint'($signed($urandom));
					write_point(idx, fit32(k), rand_val());
				end else begin
					query(pick_x(n));
				end
			end
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
